// File: src/ipv4_header_check_macros.svh
// ----------------------------------------------------------------------------
// ipv4_header_check assertion macros
// Clocked property shorthands shared by the IPv4 header checker modules.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_CHECK_MACROS_SVH
`define IPV4_HEADER_CHECK_MACROS_SVH

// same-cycle implication, disabled during reset
`define IHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ihc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_pkg
// Constants, codes and types of the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int HEADER_WORDS = 10;
    localparam int WORD_POS_W   = $clog2(HEADER_WORDS);

    localparam logic [WORD_POS_W-1:0] VERSION_WORD  = WORD_POS_W'(0);
    localparam logic [WORD_POS_W-1:0] TTL_WORD      = WORD_POS_W'(4);
    localparam logic [WORD_POS_W-1:0] CHECKSUM_WORD = WORD_POS_W'(5);
    localparam logic [WORD_POS_W-1:0] SRC_HI_WORD   = WORD_POS_W'(6);
    localparam logic [WORD_POS_W-1:0] SRC_LO_WORD   = WORD_POS_W'(7);
    localparam logic [WORD_POS_W-1:0] DST_HI_WORD   = WORD_POS_W'(8);
    localparam logic [WORD_POS_W-1:0] DST_LO_WORD   = WORD_POS_W'(9);
    localparam logic [WORD_POS_W-1:0] LAST_WORD     = WORD_POS_W'(HEADER_WORDS - 1);

    localparam logic [15:0] SUM_INIT = 16'hffff;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_VER = 2'd1;
    localparam logic [1:0] STATUS_BAD_CKS = 2'd2;

    localparam logic [1:0] CLASS_ICMP  = 2'd0;
    localparam logic [1:0] CLASS_UDP   = 2'd1;
    localparam logic [1:0] CLASS_OTHER = 2'd2;

    localparam int          CFG_ADDR_W   = 3;
    localparam int          CFG_DATA_W   = 32;
    localparam logic        REG_EXP_VL   = 1'b0;
    localparam logic [7:0]  EXP_VL_RESET = 8'h45;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  protocol_class;
        logic [7:0]  time_to_live;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } result_t;

endpackage

// File: src/ihc_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_apb_regs
// APB register file holding the expected version/length byte.
// ----------------------------------------------------------------------------
module ihc_apb_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ihc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ihc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ihc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [7:0]                     expected_version_length
);

    logic [7:0] exp_vl_reg;
    logic [7:0] exp_vl_next;
    logic       wr_en;
    logic       sel_exp_vl;

    assign pready     = 1'b1;
    assign sel_exp_vl = paddr[ihc_pkg::CFG_ADDR_W-1] == ihc_pkg::REG_EXP_VL;
    assign wr_en      = psel && penable && pwrite && pready;

    always_comb
    begin
        exp_vl_next = exp_vl_reg;
        if (wr_en && sel_exp_vl)
        begin
            exp_vl_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_vl_reg <= ihc_pkg::EXP_VL_RESET;
        end
        else
        begin
            exp_vl_reg <= exp_vl_next;
        end
    end

    assign prdata = sel_exp_vl ? {(ihc_pkg::CFG_DATA_W - 8)'(0), exp_vl_reg} : '0;
    assign expected_version_length = exp_vl_reg;

endmodule

// File: src/ihc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_core
// Input register, per-header state and checksum fold; emits one result per
// completed header.
// ----------------------------------------------------------------------------
`include "ipv4_header_check_macros.svh"

module ihc_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            header_word,
    input  logic                   start_of_header,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             expected_version_length,
    output logic                   res_valid,
    input  logic                   res_ready,
    output ihc_pkg::result_t       result
);

    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic [15:0]                   word_reg;
    logic                          start_reg;

    logic [ihc_pkg::WORD_POS_W-1:0] pos_reg;
    logic [ihc_pkg::WORD_POS_W-1:0] pos_next;
    logic [15:0]                   sum_reg;
    logic [15:0]                   sum_next;
    logic [15:0]                   cks_reg;
    logic [15:0]                   cks_next;
    logic                          vbad_reg;
    logic                          vbad_next;
    logic [7:0]                    ttl_reg;
    logic [7:0]                    ttl_next;
    logic [7:0]                    proto_reg;
    logic [7:0]                    proto_next;
    logic [31:0]                   src_reg;
    logic [31:0]                   src_next;
    logic [15:0]                   dst_hi_reg;
    logic [15:0]                   dst_hi_next;
    logic [15:0]                   dst_lo_reg;
    logic [15:0]                   dst_lo_next;

    logic [ihc_pkg::WORD_POS_W-1:0] idx;
    logic                          active;
    logic                          last;
    logic                          fire;
    logic                          advance;
    logic                          upd;
    logic [15:0]                   sum_base;
    logic [16:0]                   sum_add;
    logic [15:0]                   sum_fold;

    assign idx      = start_reg ? ihc_pkg::VERSION_WORD : pos_reg;
    assign active   = in_vld_reg && (start_reg || (pos_reg != ihc_pkg::VERSION_WORD));
    assign last     = idx == ihc_pkg::LAST_WORD;
    assign fire     = active && last;
    assign advance  = in_vld_reg && (!fire || res_ready);
    assign upd      = advance && active;
    assign in_ready = !in_vld_reg || advance;

    assign sum_base = start_reg ? ihc_pkg::SUM_INIT : sum_reg;
    assign sum_add  = {1'b0, sum_base} + {1'b0, word_reg};
    assign sum_fold = sum_add[16] ? (sum_add[15:0] + 16'd1) : sum_add[15:0];

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ready)
        begin
            in_vld_next = in_valid;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = (idx == ihc_pkg::CHECKSUM_WORD) ? sum_base : sum_fold;
        cks_next    = (idx == ihc_pkg::CHECKSUM_WORD) ? word_reg : cks_reg;
        vbad_next   = (idx == ihc_pkg::VERSION_WORD)
                    ? (word_reg[15:8] != expected_version_length) : vbad_reg;
        ttl_next    = (idx == ihc_pkg::TTL_WORD) ? word_reg[15:8] : ttl_reg;
        proto_next  = (idx == ihc_pkg::TTL_WORD) ? word_reg[7:0] : proto_reg;
        src_next    = src_reg;
        dst_hi_next = (idx == ihc_pkg::DST_HI_WORD) ? word_reg : dst_hi_reg;
        dst_lo_next = (idx == ihc_pkg::DST_LO_WORD) ? word_reg : dst_lo_reg;
        if (idx == ihc_pkg::SRC_HI_WORD)
        begin
            src_next[31:16] = word_reg;
        end
        if (idx == ihc_pkg::SRC_LO_WORD)
        begin
            src_next[15:0] = word_reg;
        end
        if (upd)
        begin
            pos_next = last ? ihc_pkg::VERSION_WORD
                            : idx + ihc_pkg::WORD_POS_W'(1);
        end
    end

    always_comb
    begin
        if (vbad_next)
        begin
            result.status = ihc_pkg::STATUS_BAD_VER;
        end
        else if (~sum_next != cks_next)
        begin
            result.status = ihc_pkg::STATUS_BAD_CKS;
        end
        else
        begin
            result.status = ihc_pkg::STATUS_OK;
        end
        case (proto_next)
            ihc_pkg::PROTO_ICMP: result.protocol_class = ihc_pkg::CLASS_ICMP;
            ihc_pkg::PROTO_UDP:  result.protocol_class = ihc_pkg::CLASS_UDP;
            default:             result.protocol_class = ihc_pkg::CLASS_OTHER;
        endcase
        result.time_to_live        = ttl_next;
        result.source_address      = src_next;
        result.destination_address = {dst_hi_next, dst_lo_next};
    end

    assign res_valid = fire && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            pos_reg    <= ihc_pkg::VERSION_WORD;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg  <= header_word;
            start_reg <= start_of_header;
        end
        if (upd)
        begin
            sum_reg    <= sum_next;
            cks_reg    <= cks_next;
            vbad_reg   <= vbad_next;
            ttl_reg    <= ttl_next;
            proto_reg  <= proto_next;
            src_reg    <= src_next;
            dst_hi_reg <= dst_hi_next;
            dst_lo_reg <= dst_lo_next;
        end
    end

    `IHC_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, pos_reg <= ihc_pkg::LAST_WORD,
        "word position out of range")
    `IHC_ASSERT_NOW(a_res_slot, clk, rst_n, res_valid, res_ready && upd,
        "result issued without a free slot")
    `IHC_ASSERT_NEXT(a_pos_step, clk, rst_n, upd && !last,
        pos_reg == $past(idx) + ihc_pkg::WORD_POS_W'(1), "word position did not advance")

endmodule

// File: src/ipv4_header_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_check
// IPv4 header checker: version byte, ones' complement checksum, protocol
// class, TTL and addresses, one result per header.
// ----------------------------------------------------------------------------
//  channel  signals                               moves
//  in       in_valid / in_ready                   one header word transaction
//  out      out_valid / out_ready                 one header result transaction
//  cfg      psel penable pwrite paddr pwdata      expected version/length byte
//
//  One header word per cycle while each finished result can issue; after
//  its last word is taken, the result of a header passes the input
//  register, then the output register, before it is presented.
//  Reset clears the valid flags and the word position, and sets the config register to 0x45.
//  A held result stalls input only when the next result is ready to issue.
// ----------------------------------------------------------------------------
`include "ipv4_header_check_macros.svh"

module ipv4_header_check
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [15:0]                    header_word,
    input  logic                           start_of_header,
    input  logic                           in_valid,
    output logic                           in_ready,
    output logic [1:0]                     status,
    output logic [1:0]                     protocol_class,
    output logic [7:0]                     time_to_live,
    output logic [31:0]                    source_address,
    output logic [31:0]                    destination_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ihc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ihc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ihc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [7:0]        exp_vl;
    logic              res_valid;
    logic              res_ready;
    ihc_pkg::result_t  res;
    ihc_pkg::result_t  out_reg;
    logic              out_vld_reg;
    logic              out_vld_next;

    ihc_apb_regs u_regs
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .expected_version_length (exp_vl)
    );

    assign res_ready = !out_vld_reg || out_ready;

    ihc_core u_core
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .header_word             (header_word),
        .start_of_header         (start_of_header),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .expected_version_length (exp_vl),
        .res_valid               (res_valid),
        .res_ready               (res_ready),
        .result                  (res)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_valid)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid           = out_vld_reg;
    assign status              = out_reg.status;
    assign protocol_class      = out_reg.protocol_class;
    assign time_to_live        = out_reg.time_to_live;
    assign source_address      = out_reg.source_address;
    assign destination_address = out_reg.destination_address;

    `IHC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid,
        status == ihc_pkg::STATUS_OK || status == ihc_pkg::STATUS_BAD_VER
        || status == ihc_pkg::STATUS_BAD_CKS, "illegal status code")
    `IHC_ASSERT_NEXT(a_res_loaded, clk, rst_n, res_valid, out_valid,
        "issued result not presented")
    `IHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_reg), "held result changed before acceptance")

endmodule
